@@ design/tpspwm_pkg.sv @@
// Shared types, constants and the sine table generator for the three-phase duty core.
`timescale 1ns / 1ps

package tpspwm_pkg;

    // Full-scale compare value of the PWM timer
    localparam logic [15:0] PWM_PERIOD = 16'd4096;

    // Steps per quarter turn of the sine table, as a power of two
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam logic [15:0] LIMIT_A_RESET = 16'd1638;
    localparam logic [15:0] LIMIT_B_RESET = 16'd1843;

    // Register indexes on the configuration port
    localparam logic REG_LIMIT_A = 1'b0;
    localparam logic REG_LIMIT_B = 1'b1;

    localparam int NUM_PHASES = 3;

    // Phase offsets: 0, 120 and 240 degrees of a 16-bit turn
    localparam logic [15:0] PHASE_OFFSET [NUM_PHASES] = '{16'd0, 16'd21845, 16'd43691};

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        MODE_LOW  = 2'd0,
        MODE_HIGH = 2'd1,
        MODE_CMP  = 2'd2
    } pin_mode_t;

    typedef struct packed {
        logic        neg;
        logic [14:0] mag;
    } phase_in_t;

    typedef struct packed {
        logic [15:0] duty;
        pin_mode_t   mode;
    } phase_out_t;

    // x^2 step of the Taylor series in Q30
    function automatic logic [63:0] taylor_step(logic [63:0] term, logic [63:0] x);
        logic [63:0] t;
        t = (term * x) >> 30;
        t = (t * x) >> 30;
        return t;
    endfunction

    // Table entry i: sin(i * (pi/2) / 2^bits) in Q0.15, evaluated at elaboration
    function automatic logic [14:0] sine_entry(int unsigned i, int unsigned bits);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        q;
        x    = (64'(i) * HALF_PI_Q30) >> bits;
        term = x;
        sum  = $signed(x);
        term = taylor_step(term, x) / 64'd6;
        sum  = sum - $signed(term);
        term = taylor_step(term, x) / 64'd20;
        sum  = sum + $signed(term);
        term = taylor_step(term, x) / 64'd42;
        sum  = sum - $signed(term);
        term = taylor_step(term, x) / 64'd72;
        sum  = sum + $signed(term);
        term = taylor_step(term, x) / 64'd110;
        sum  = sum - $signed(term);
        term = taylor_step(term, x) / 64'd156;
        sum  = sum + $signed(term);
        term = taylor_step(term, x) / 64'd210;
        sum  = sum - $signed(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        q = ($unsigned(sum) + 64'd16384) >> 15;
        if (q > 64'd32767)
        begin
            q = 64'd32767;
        end
        return q[14:0];
    endfunction

endpackage

@@ design/tpspwm_sine_rom.sv @@
// Quarter-wave sine ROM, Q0.15 magnitude, registered read.
`timescale 1ns / 1ps

module tpspwm_sine_rom #(
    parameter int TABLE_BITS = tpspwm_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [TABLE_BITS:0]   addr,
    output logic [14:0]           data
);
    import tpspwm_pkg::*;

    localparam int DEPTH = (1 << TABLE_BITS) + 1;

    typedef logic [14:0] rom_t [DEPTH];

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i < DEPTH; i++)
        begin
            r[i] = sine_entry(i, TABLE_BITS);
        end
        return r;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [14:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= ROM[addr];
        end
    end

    assign data = data_reg;

endmodule

@@ design/tpspwm_phase_duty.sv @@
// Duty scaling, saturation and pin mode for one phase.
`timescale 1ns / 1ps

module tpspwm_phase_duty (
    input  logic [14:0]            half,
    input  tpspwm_pkg::phase_in_t  sine,
    output tpspwm_pkg::phase_out_t result
);
    import tpspwm_pkg::*;

    logic [16:0] factor;
    logic [30:0] prod;
    logic [15:0] duty_raw;
    logic [15:0] duty_sat;

    // 1 + sin in Q15, always within 1 .. 65535
    assign factor = sine.neg ? (17'd32768 - {2'b00, sine.mag})
                             : (17'd32768 + {2'b00, sine.mag});
    assign prod     = 31'(half) * 31'(factor[15:0]);
    assign duty_raw = prod[30:15];
    assign duty_sat = (duty_raw > PWM_PERIOD) ? PWM_PERIOD : duty_raw;

    always_comb
    begin
        result.duty = duty_sat;
        if (duty_sat == 16'd0)
        begin
            result.mode = MODE_LOW;
        end
        else if (duty_sat == PWM_PERIOD)
        begin
            result.mode = MODE_HIGH;
        end
        else
        begin
            result.mode = MODE_CMP;
        end
    end

endmodule

@@ design/three_phase_sine_pwm_duty_core.sv @@
// Top level of the three-phase sinusoidal PWM duty core.
//
//  channel   signals                         word
//  -------   -----------------------------   -------------------------------------
//  command   cmd_valid / cmd_stall           command, angle
//  result    duty_valid / duty_stall         channel, duty_u/v/w, mode_u/v/w
//  config    cfg_valid / cfg_ready           cfg_index, cfg_data
//
// One word per cycle sustained while duty_stall is low; from acceptance to duty_valid
// a word passes the sine ROM read register, then the result register after the multiply.
// Reset loads limit_a and limit_b with their defaults and empties both stages.
// A stall on the result side holds the result stage once full, and the first stage once both are full;
// cmd_stall rises only when both stages are full and the result word is not being taken.
// cfg_ready is always high.
`timescale 1ns / 1ps

module three_phase_sine_pwm_duty_core #(
    parameter int SINE_TABLE_BITS = tpspwm_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic        command,
    input  logic [15:0] angle,

    output logic        duty_valid,
    input  logic        duty_stall,
    output logic        channel,
    output logic [15:0] duty_u,
    output logic [15:0] duty_v,
    output logic [15:0] duty_w,
    output logic [1:0]  mode_u,
    output logic [1:0]  mode_v,
    output logic [1:0]  mode_w,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import tpspwm_pkg::*;

    localparam int B = SINE_TABLE_BITS;
    localparam logic [B:0] FULL = (B + 1)'(1) << B;

    logic [15:0] limit_a_reg, limit_a_next;
    logic [15:0] limit_b_reg, limit_b_next;

    logic        v1_reg, v1_next;
    logic        v2_reg, v2_next;
    logic        en1, en2;

    logic        chan1_reg;
    logic [14:0] half1_reg;
    logic        neg1_reg [NUM_PHASES];

    logic        chan2_reg;
    phase_out_t  res2_reg [NUM_PHASES];

    logic [B:0]  rom_addr [NUM_PHASES];
    logic [14:0] rom_data [NUM_PHASES];
    phase_out_t  res_comb [NUM_PHASES];

    // Stage enables: a stage moves when it is empty or its successor moves
    assign en2       = !v2_reg || !duty_stall;
    assign en1       = !v1_reg || en2;
    assign cmd_stall = !en1;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        limit_a_next = limit_a_reg;
        limit_b_next = limit_b_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_LIMIT_A: limit_a_next = cfg_data;
                REG_LIMIT_B: limit_b_next = cfg_data;
                default:     ;
            endcase
        end
    end

    assign v1_next = en1 ? cmd_valid : v1_reg;
    assign v2_next = en2 ? v1_reg : v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_a_reg <= LIMIT_A_RESET;
            limit_b_reg <= LIMIT_B_RESET;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
        end
        else
        begin
            limit_a_reg <= limit_a_next;
            limit_b_reg <= limit_b_next;
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
        end
    end

    genvar k;
    generate
        for (k = 0; k < NUM_PHASES; k++)
        begin : g_phase
            logic [15:0] ph;
            logic [B-1:0] j;
            phase_in_t    sin_in;

            assign ph = angle + PHASE_OFFSET[k];
            assign j  = ph[13 -: B];
            // odd quadrants read the table mirrored
            assign rom_addr[k] = ph[14] ? (FULL - {1'b0, j}) : {1'b0, j};

            tpspwm_sine_rom #(
                .TABLE_BITS (B)
            ) u_rom (
                .clk  (clk),
                .en   (en1),
                .addr (rom_addr[k]),
                .data (rom_data[k])
            );

            always_ff @(posedge clk)
            begin
                if (en1)
                begin
                    neg1_reg[k] <= ph[15];
                end
            end

            assign sin_in.neg = neg1_reg[k];
            assign sin_in.mag = rom_data[k];

            tpspwm_phase_duty u_duty (
                .half   (half1_reg),
                .sine   (sin_in),
                .result (res_comb[k])
            );

            always_ff @(posedge clk)
            begin
                if (en2)
                begin
                    res2_reg[k] <= res_comb[k];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            chan1_reg <= command;
            half1_reg <= command ? limit_b_reg[15:1] : limit_a_reg[15:1];
        end
        if (en2)
        begin
            chan2_reg <= chan1_reg;
        end
    end

    assign duty_valid = v2_reg;
    assign channel    = chan2_reg;
    assign duty_u     = res2_reg[0].duty;
    assign duty_v     = res2_reg[1].duty;
    assign duty_w     = res2_reg[2].duty;
    assign mode_u     = res2_reg[0].mode;
    assign mode_v     = res2_reg[1].mode;
    assign mode_w     = res2_reg[2].mode;

endmodule
